// ===== hw/rtl/jtm_pkg.sv =====
// ----------------------------------------------------------------------------
// jtm_pkg: shared types and constants for the joystick to mouse delta block
// Item structs for the sample and report channels, register indexes and
// reset values of the configuration registers.
// ----------------------------------------------------------------------------
package jtm_pkg;

  localparam int CAL_SAMPLES_DEF  = 80;
  localparam int MAX_ATTEMPTS_DEF = 320;

  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 3;

  localparam logic [6:0]  DEADZONE_RST = 7'd9;
  localparam logic [15:0] GAIN_RST     = 16'd7209;
  localparam logic [6:0]  MAX_STEP_RST = 7'd12;
  localparam logic        INVERT_X_RST = 1'b0;
  localparam logic        INVERT_Y_RST = 1'b1;
  localparam logic [7:0]  CENTER_RST   = 8'd128;

  localparam logic REQ_SAMPLE    = 1'b0;
  localparam logic REQ_CALIBRATE = 1'b1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_DEADZONE = 3'd0,
    CFG_GAIN     = 3'd1,
    CFG_MAX_STEP = 3'd2,
    CFG_INVERT_X = 3'd3,
    CFG_INVERT_Y = 3'd4
  } cfg_index_t;

  typedef struct packed {
    logic       req_type;
    logic       read_ok;
    logic [7:0] stick_x;
    logic [7:0] stick_y;
    logic [7:0] button_byte;
  } in_item_t;

  typedef struct packed {
    logic              report_valid;
    logic [1:0]        buttons;
    logic signed [7:0] delta_x;
    logic signed [7:0] delta_y;
    logic              read_fault;
    logic              ready_res;
    logic              calibrating;
    logic [7:0]        center_x_out;
    logic [7:0]        center_y_out;
  } out_item_t;

endpackage

// ===== hw/rtl/joystick_to_mouse_delta.sv =====
// ----------------------------------------------------------------------------
// joystick_to_mouse_delta: joystick samples to relative mouse reports
// Calibrates the stick center, then removes center and dead zone, applies
// a Q0.16 gain with rounding and clamps each delta to the step limit.
// ----------------------------------------------------------------------------
// Usage:
//   The in channel (in_valid/in_ready/in_data) takes one request item:
//   a joystick sample or a calibrate request. Every item yields exactly one
//   item on the out channel (out_valid/out_ready/out_data), holding the
//   report fields and the block status after that item.
//   out_valid rises once the accepted item has left the input register: the
//   item sits there until the result register can take it, and the per-item
//   logic then writes the result register.
//   Throughput is one item per clock while out_ready is high; state is
//   written with the result, and a finished calibration divides the sums
//   by a reciprocal multiply so the next sample already sees the new center.
//   cfg_we/cfg_index/cfg_data write one register per cycle; the user must
//   write them only while no item is in flight, the block does not enforce it.
//   Synchronous reset (rst) empties both registers, restores the register
//   defaults, sets both centers to 128 and leaves the block not ready.
//   When out_ready is low, the result item holds and the input register
//   still fills; in_ready drops only when both are occupied.
// ----------------------------------------------------------------------------
module joystick_to_mouse_delta #(
  parameter int CAL_SAMPLES  = jtm_pkg::CAL_SAMPLES_DEF,
  parameter int MAX_ATTEMPTS = jtm_pkg::MAX_ATTEMPTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  jtm_pkg::in_item_t               in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output jtm_pkg::out_item_t              out_data,
  input  logic                            cfg_we,
  input  logic [jtm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [jtm_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int SUM_W  = $clog2(CAL_SAMPLES * 255 + 1);
  localparam int GOOD_W = $clog2(CAL_SAMPLES + 1);
  localparam int ATT_W  = $clog2(MAX_ATTEMPTS + 1);
  // Exact floor division by CAL_SAMPLES for any SUM_W-bit sum.
  localparam int RSHIFT = SUM_W + 8;
  localparam int unsigned RECIP = ((1 << RSHIFT) + CAL_SAMPLES - 1) / CAL_SAMPLES;
  localparam int PROD_W = SUM_W + RSHIFT + 1;

  localparam logic [GOOD_W-1:0] GOOD_LIMIT = GOOD_W'(CAL_SAMPLES);
  localparam logic [ATT_W-1:0]  ATT_LIMIT  = ATT_W'(MAX_ATTEMPTS);
  localparam logic [RSHIFT:0]   RECIP_V    = (RSHIFT + 1)'(RECIP);

  // Configuration registers.
  logic [6:0]  deadzone;
  logic [15:0] gain_q16;
  logic [6:0]  max_step;
  logic        invert_x;
  logic        invert_y;

  // Block state.
  logic [7:0]        center_x, center_y;
  logic [SUM_W-1:0]  sum_x, sum_y;
  logic [GOOD_W-1:0] good_count;
  logic [ATT_W-1:0]  attempt_count;
  logic              is_ready, is_calibrating, fault_flag;

  logic [7:0]        center_x_next, center_y_next;
  logic [SUM_W-1:0]  sum_x_next, sum_y_next;
  logic [GOOD_W-1:0] good_count_next;
  logic [ATT_W-1:0]  attempt_count_next;
  logic              is_ready_next, is_calibrating_next, fault_flag_next;

  logic              s1_valid;
  jtm_pkg::in_item_t s1_data;
  logic              advance;
  jtm_pkg::out_item_t result;

  logic [PROD_W-1:0] div_x, div_y;
  logic signed [7:0] dx, dy;

  function automatic logic signed [7:0] axis_delta(
    input logic [7:0]  pos,
    input logic [7:0]  ctr,
    input logic        inv,
    input logic [6:0]  dz,
    input logic [15:0] gain,
    input logic [6:0]  mx
  );
    logic signed [8:0] off;
    logic              neg;
    logic [7:0]        mag;
    logic [7:0]        m2;
    logic [23:0]       prod;
    logic [24:0]       rnd;
    logic [7:0]        qv;
    logic [6:0]        qc;
    logic [7:0]        res;
    off  = $signed({1'b0, pos}) - $signed({1'b0, ctr});
    neg  = off[8];
    mag  = neg ? 8'(-off) : off[7:0];
    m2   = mag - {1'b0, dz};
    prod = m2 * gain;
    rnd  = {1'b0, prod} + 25'd32768;
    qv   = rnd[23:16];
    if (qv == 8'd0) begin
      qv = 8'd1;
    end
    if (qv > {1'b0, mx}) begin
      qv = {1'b0, mx};
    end
    qc  = qv[6:0];
    neg = neg ^ inv;
    res = neg ? 8'(-{1'b0, qc}) : {1'b0, qc};
    if (mag <= {1'b0, dz}) begin
      res = 8'd0;
    end
    return $signed(res);
  endfunction

  assign advance  = !out_valid || out_ready;
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      deadzone <= jtm_pkg::DEADZONE_RST;
      gain_q16 <= jtm_pkg::GAIN_RST;
      max_step <= jtm_pkg::MAX_STEP_RST;
      invert_x <= jtm_pkg::INVERT_X_RST;
      invert_y <= jtm_pkg::INVERT_Y_RST;
    end else if (cfg_we) begin
      case (jtm_pkg::cfg_index_t'(cfg_index))
        jtm_pkg::CFG_DEADZONE: deadzone <= cfg_data[6:0];
        jtm_pkg::CFG_GAIN:     gain_q16 <= cfg_data;
        jtm_pkg::CFG_MAX_STEP: max_step <= cfg_data[6:0];
        jtm_pkg::CFG_INVERT_X: invert_x <= cfg_data[0];
        jtm_pkg::CFG_INVERT_Y: invert_y <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Centers for a calibration that completes with this item.
  assign div_x = PROD_W'(sum_x_next) * PROD_W'(RECIP_V);
  assign div_y = PROD_W'(sum_y_next) * PROD_W'(RECIP_V);

  assign dx = axis_delta(s1_data.stick_x, center_x, invert_x, deadzone, gain_q16, max_step);
  assign dy = axis_delta(s1_data.stick_y, center_y, invert_y, deadzone, gain_q16, max_step);

  always_comb begin
    center_x_next       = center_x;
    center_y_next       = center_y;
    sum_x_next          = sum_x;
    sum_y_next          = sum_y;
    good_count_next     = good_count;
    attempt_count_next  = attempt_count;
    is_ready_next       = is_ready;
    is_calibrating_next = is_calibrating;
    fault_flag_next     = fault_flag;
    result              = '0;

    if (s1_data.req_type == jtm_pkg::REQ_CALIBRATE) begin
      sum_x_next          = '0;
      sum_y_next          = '0;
      good_count_next     = '0;
      attempt_count_next  = '0;
      is_calibrating_next = 1'b1;
      is_ready_next       = 1'b0;
      fault_flag_next     = 1'b0;
    end else if (is_calibrating) begin
      attempt_count_next = attempt_count + 1'b1;
      if (s1_data.read_ok) begin
        sum_x_next      = sum_x + SUM_W'(s1_data.stick_x);
        sum_y_next      = sum_y + SUM_W'(s1_data.stick_y);
        good_count_next = good_count + 1'b1;
      end
      if (good_count_next >= GOOD_LIMIT) begin
        center_x_next       = div_x[RSHIFT +: 8];
        center_y_next       = div_y[RSHIFT +: 8];
        is_calibrating_next = 1'b0;
        is_ready_next       = 1'b1;
        fault_flag_next     = 1'b0;
      end else if (attempt_count_next >= ATT_LIMIT) begin
        is_calibrating_next = 1'b0;
        is_ready_next       = 1'b0;
        fault_flag_next     = 1'b0;
      end
    end else if (is_ready) begin
      result.report_valid = 1'b1;
      if (!s1_data.read_ok) begin
        fault_flag_next = 1'b1;
      end else begin
        fault_flag_next    = 1'b0;
        result.delta_x     = dx;
        result.delta_y     = dy;
        result.buttons     = ~s1_data.button_byte[1:0];
      end
    end

    result.read_fault   = fault_flag_next;
    result.ready_res    = is_ready_next;
    result.calibrating  = is_calibrating_next;
    result.center_x_out = center_x_next;
    result.center_y_out = center_y_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid       <= 1'b0;
      out_valid      <= 1'b0;
      center_x       <= jtm_pkg::CENTER_RST;
      center_y       <= jtm_pkg::CENTER_RST;
      sum_x          <= '0;
      sum_y          <= '0;
      good_count     <= '0;
      attempt_count  <= '0;
      is_ready       <= 1'b0;
      is_calibrating <= 1'b0;
      fault_flag     <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (advance) begin
        out_valid <= s1_valid;
        if (s1_valid) begin
          center_x       <= center_x_next;
          center_y       <= center_y_next;
          sum_x          <= sum_x_next;
          sum_y          <= sum_y_next;
          good_count     <= good_count_next;
          attempt_count  <= attempt_count_next;
          is_ready       <= is_ready_next;
          is_calibrating <= is_calibrating_next;
          fault_flag     <= fault_flag_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      s1_data <= in_data;
    end
    if (advance && s1_valid) begin
      out_data <= result;
    end
  end

  // Calibration ends on the sample that brings the good count to the limit.
  a_good_within_limit: assert property (@(posedge clk) disable iff (rst)
    good_count <= GOOD_LIMIT)
    else $error("good_count passed CAL_SAMPLES");

  a_ready_xor_cal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.ready_res && out_data.calibrating))
    else $error("result item reports ready and calibrating at once");

  a_report_when_ready: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.report_valid |-> out_data.ready_res)
    else $error("report produced while not ready");

  a_delta_clamped: assert property (@(posedge clk) disable iff (rst)
    s1_valid && advance && result.report_valid |->
      ($signed({dx[7], dx}) <= $signed({2'b00, max_step}))
      && ($signed({dx[7], dx}) >= -$signed({2'b00, max_step})))
    else $error("delta_x exceeds max_step");

endmodule

// ===== sim/joystick_to_mouse_delta_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// joystick_to_mouse_delta_test: self-checking bench for the mouse delta block
// Drives calibrate requests and joystick samples through the valid/ready
// input channel under random bursts, and predicts every report item from a
// local model of the calibration state and the axis transfer curve. Reports
// are compared field by field while the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module joystick_to_mouse_delta_test;

  localparam int CAL_COUNT   = jtm_pkg::CAL_SAMPLES_DEF;
  localparam int ATTEMPT_CAP = jtm_pkg::MAX_ATTEMPTS_DEF;
  localparam int STALL_LIMIT = 5000;

  typedef enum int {
    RX_STEADY,
    RX_COIN,
    RX_THREE_OF_FOUR,
    RX_SPARSE
  } rx_mode_t;

  logic                            clk;
  logic                            rst;
  logic                            in_valid;
  logic                            in_ready;
  jtm_pkg::in_item_t               in_data;
  logic                            out_valid;
  logic                            out_ready;
  jtm_pkg::out_item_t              out_data;
  logic                            cfg_we;
  logic [jtm_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [jtm_pkg::CFG_DATA_W-1:0]  cfg_data;

  // Local copy of the registers and of the calibration state.
  logic [6:0]  dz_reg;
  logic [15:0] gain_reg;
  logic [6:0]  step_reg;
  logic        inv_x_reg;
  logic        inv_y_reg;
  logic [7:0]  ctr_x;
  logic [7:0]  ctr_y;
  int          acc_x;
  int          acc_y;
  int          good_seen;
  int          attempts;
  logic        pred_ready;
  logic        pred_cal;
  logic        pred_fault;

  jtm_pkg::out_item_t expected_reports[$];

  int       burst_left;
  int       items_sent;
  int       reports_checked;
  int       cal_requests;
  int       settings_applied;
  int       error_count;
  int       idle_cycles;
  int       rx_cycle;
  int       rx_left;
  rx_mode_t rx_mode;

  joystick_to_mouse_delta uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Dead zone, Q0.16 gain with rounding half away from zero, inversion,
  // the minimum of one step and the clamp, for one axis.
  function automatic logic signed [7:0] axis_step(input int offset, input logic invert);
    logic neg;
    int   mag;
    int   q;
    neg = offset < 0;
    mag = neg ? -offset : offset;
    if (mag <= int'(dz_reg)) return 8'sd0;
    mag = mag - int'(dz_reg);
    q = (mag * int'(gain_reg) + 32768) >>> 16;
    if (q == 0) q = 1;
    if (q > int'(step_reg)) q = int'(step_reg);
    if (invert) neg = !neg;
    return neg ? 8'(-q) : 8'(q);
  endfunction

  function automatic jtm_pkg::out_item_t predict_report(input jtm_pkg::in_item_t it);
    jtm_pkg::out_item_t r;
    r = '0;
    if (it.req_type == jtm_pkg::REQ_CALIBRATE) begin
      acc_x = 0;
      acc_y = 0;
      good_seen = 0;
      attempts = 0;
      pred_cal = 1'b1;
      pred_ready = 1'b0;
      pred_fault = 1'b0;
    end else if (pred_cal) begin
      attempts++;
      if (it.read_ok) begin
        acc_x += int'(it.stick_x);
        acc_y += int'(it.stick_y);
        good_seen++;
      end
      // A full set of good samples wins over the attempt limit.
      if (good_seen >= CAL_COUNT) begin
        ctr_x = 8'(acc_x / CAL_COUNT);
        ctr_y = 8'(acc_y / CAL_COUNT);
        pred_cal = 1'b0;
        pred_ready = 1'b1;
        pred_fault = 1'b0;
      end else if (attempts >= ATTEMPT_CAP) begin
        pred_cal = 1'b0;
        pred_ready = 1'b0;
        pred_fault = 1'b0;
      end
    end else if (pred_ready) begin
      r.report_valid = 1'b1;
      if (!it.read_ok) begin
        pred_fault = 1'b1;
      end else begin
        pred_fault = 1'b0;
        r.delta_x = axis_step(int'(it.stick_x) - int'(ctr_x), inv_x_reg);
        r.delta_y = axis_step(int'(it.stick_y) - int'(ctr_y), inv_y_reg);
        r.buttons[0] = ~it.button_byte[0];
        r.buttons[1] = ~it.button_byte[1];
      end
    end
    r.read_fault = pred_fault;
    r.ready_res = pred_ready;
    r.calibrating = pred_cal;
    r.center_x_out = ctr_x;
    r.center_y_out = ctr_y;
    return r;
  endfunction

  function automatic jtm_pkg::in_item_t make_item(input logic req, input logic ok,
                                                  input int x, input int y, input int btn);
    jtm_pkg::in_item_t it;
    it.req_type = req;
    it.read_ok = ok;
    it.stick_x = 8'(x);
    it.stick_y = 8'(y);
    it.button_byte = 8'(btn);
    return it;
  endfunction

  function automatic int clip_byte(input int v);
    if (v < 0) return 0;
    if (v > 255) return 255;
    return v;
  endfunction

  task automatic flag_error(input string what, input int want, input int got);
    error_count++;
    if (error_count <= 10) begin
      $display("ERROR at %0t ns: %s expected %0d, got %0d", $time, what, want, got);
    end
  endtask

  // Sends one item; the sender runs in bursts with random gaps in between.
  task automatic send_item(input jtm_pkg::in_item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        in_valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid = 1'b1;
    in_data = it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_reports.push_back(predict_report(it));
    items_sent++;
  endtask

  // Stops sending and waits until every predicted report has arrived.
  task automatic settle_block();
    @(negedge clk);
    in_valid = 1'b0;
    burst_left = 0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input jtm_pkg::cfg_index_t idx, input int value);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = 16'(value);
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      jtm_pkg::CFG_DEADZONE: dz_reg = 7'(value);
      jtm_pkg::CFG_GAIN:     gain_reg = 16'(value);
      jtm_pkg::CFG_MAX_STEP: step_reg = 7'(value);
      jtm_pkg::CFG_INVERT_X: inv_x_reg = 1'(value);
      jtm_pkg::CFG_INVERT_Y: inv_y_reg = 1'(value);
      default: ;
    endcase
  endtask

  task automatic apply_settings(input int dz, input int gain, input int step, input int ix,
                                input int iy);
    settle_block();
    write_reg(jtm_pkg::CFG_DEADZONE, dz);
    write_reg(jtm_pkg::CFG_GAIN, gain);
    write_reg(jtm_pkg::CFG_MAX_STEP, step);
    write_reg(jtm_pkg::CFG_INVERT_X, ix);
    write_reg(jtm_pkg::CFG_INVERT_Y, iy);
    settings_applied++;
  endtask

  // Calibrate request followed by samples around a chosen center until the
  // calibration ends, either with new centers or by running out of attempts.
  task automatic calibrate(input int cx, input int cy, input int spread, input int bad_pct);
    int x;
    int y;
    send_item(make_item(jtm_pkg::REQ_CALIBRATE, 1'($urandom), $urandom, $urandom,
                        $urandom));
    cal_requests++;
    while (pred_cal) begin
      x = $urandom_range(0, 2 * spread);
      y = $urandom_range(0, 2 * spread);
      send_item(make_item(jtm_pkg::REQ_SAMPLE, $urandom_range(0, 99) >= bad_pct,
                          clip_byte(cx + x - spread), clip_byte(cy + y - spread), $urandom));
    end
  endtask

  task automatic test_idle_samples();
    send_item(make_item(jtm_pkg::REQ_SAMPLE, 1'b1, 8'h00, 8'hFF, 8'h00));
    send_item(make_item(jtm_pkg::REQ_SAMPLE, 1'b0, 8'hFF, 8'h00, 8'hFF));
    send_item(make_item(jtm_pkg::REQ_SAMPLE, 1'b1, 8'h80, 8'h80, 8'h03));
  endtask

  task automatic test_calibration_extremes();
    calibrate(255, 0, 0, 20);
    send_item(make_item(jtm_pkg::REQ_SAMPLE, 1'b1, 8'h00, 8'hFF, 8'h00));
    send_item(make_item(jtm_pkg::REQ_SAMPLE, 1'b1, 8'hFF, 8'h00, 8'h01));
    send_item(make_item(jtm_pkg::REQ_SAMPLE, 1'b0, 8'h00, 8'hFF, 8'h02));
    send_item(make_item(jtm_pkg::REQ_SAMPLE, 1'b1, 8'h80, 8'h80, 8'hFF));
    calibrate(128, 128, 0, 0);
    send_item(make_item(jtm_pkg::REQ_SAMPLE, 1'b1, 8'h00, 8'hFF, 8'hFC));
    send_item(make_item(jtm_pkg::REQ_SAMPLE, 1'b1, 8'hFF, 8'h00, 8'hFD));
  endtask

  task automatic test_register_extremes();
    // Full gain and widest clamp: offsets of one step, maximum swing.
    apply_settings(0, 65535, 127, 1, 0);
    send_item(make_item(jtm_pkg::REQ_SAMPLE, 1'b1, 8'hFF, 8'h00, 8'h00));
    send_item(make_item(jtm_pkg::REQ_SAMPLE, 1'b1, 8'h81, 8'h7F, 8'h00));
    send_item(make_item(jtm_pkg::REQ_SAMPLE, 1'b1, 8'h80, 8'h80, 8'h00));
    // Widest dead zone and zero gain: anything outside moves one step.
    apply_settings(127, 0, 1, 0, 1);
    send_item(make_item(jtm_pkg::REQ_SAMPLE, 1'b1, 8'hFF, 8'h00, 8'h00));
    send_item(make_item(jtm_pkg::REQ_SAMPLE, 1'b1, 8'h00, 8'h01, 8'h03));
    // A step limit of zero holds every delta at zero.
    apply_settings(5, 7209, 0, 1, 1);
    send_item(make_item(jtm_pkg::REQ_SAMPLE, 1'b1, 8'h85, 8'h7B, 8'h00));
    send_item(make_item(jtm_pkg::REQ_SAMPLE, 1'b1, 8'h86, 8'h7A, 8'h00));
    // A gain of one half shows rounding of exact halves away from zero.
    apply_settings(0, 32768, 127, 0, 0);
    send_item(make_item(jtm_pkg::REQ_SAMPLE, 1'b1, 8'h81, 8'h7F, 8'h02));
    send_item(make_item(jtm_pkg::REQ_SAMPLE, 1'b1, 8'h83, 8'h7D, 8'h01));
    send_item(make_item(jtm_pkg::REQ_SAMPLE, 1'b0, 8'h83, 8'h7D, 8'h01));
    send_item(make_item(jtm_pkg::REQ_SAMPLE, 1'b1, 8'h85, 8'h7B, 8'h00));
  endtask

  task automatic test_recalibration();
    int n;
    apply_settings(9, 7209, 12, 0, 1);
    // A second request in the middle of a calibration restarts it.
    send_item(make_item(jtm_pkg::REQ_CALIBRATE, 1'b0, 8'h00, 8'h00, 8'h00));
    cal_requests++;
    for (n = 0; n < 30; n++) begin
      send_item(make_item(jtm_pkg::REQ_SAMPLE, 1'b1, $urandom_range(0, 60), $urandom,
                          $urandom));
    end
    calibrate(100, 160, 15, 10);
    // Mostly failed reads: the attempt limit runs out and the block idles.
    calibrate(128, 128, 10, 90);
    send_item(make_item(jtm_pkg::REQ_SAMPLE, 1'b1, 8'h00, 8'hFF, 8'h00));
    send_item(make_item(jtm_pkg::REQ_SAMPLE, 1'b0, 8'hFF, 8'h00, 8'hFF));
    calibrate(60, 200, 30, 5);
    send_item(make_item(jtm_pkg::REQ_SAMPLE, 1'b1, 8'hFF, 8'h00, 8'h00));
    // This request arrives while the block is ready.
    calibrate(128, 128, 25, 5);
  endtask

  task automatic test_random_traffic();
    int phase;
    int n;
    int dz;
    int gain;
    int step;
    int pick;
    int w;
    int x;
    int y;
    int cal_x;
    int cal_y;
    int spread;
    cal_x = 128;
    cal_y = 128;
    spread = 10;
    for (phase = 0; phase < 3; phase++) begin
      pick = $urandom_range(0, 3);
      dz = (pick == 0) ? 0 : (pick == 1) ? 127 : $urandom_range(0, 40);
      pick = $urandom_range(0, 4);
      gain = (pick == 0) ? 0 : (pick == 1) ? 65535 :
             (pick == 2) ? $urandom_range(0, 65535) : $urandom_range(2000, 20000);
      pick = $urandom_range(0, 3);
      step = (pick == 0) ? 127 : (pick == 1) ? 1 : $urandom_range(1, 127);
      apply_settings(dz, gain, step, $urandom_range(0, 1), $urandom_range(0, 1));
      for (n = 0; n < 45; n++) begin
        if ((!pred_ready && !pred_cal && $urandom_range(0, 1) == 0) ||
            $urandom_range(0, 249) == 0) begin
          cal_x = $urandom_range(0, 255);
          cal_y = $urandom_range(0, 255);
          spread = $urandom_range(0, 30);
          send_item(make_item(jtm_pkg::REQ_CALIBRATE, 1'($urandom), $urandom, $urandom,
                              $urandom));
          cal_requests++;
        end else if (pred_cal) begin
          x = $urandom_range(0, 2 * spread);
          y = $urandom_range(0, 2 * spread);
          send_item(make_item(jtm_pkg::REQ_SAMPLE, $urandom_range(0, 9) != 0,
                              clip_byte(cal_x + x - spread), clip_byte(cal_y + y - spread),
                              $urandom));
        end else if ($urandom_range(0, 1) == 0) begin
          send_item(make_item(jtm_pkg::REQ_SAMPLE, $urandom_range(0, 14) != 0, $urandom,
                              $urandom, $urandom));
        end else begin
          // Offsets near the dead zone edge, where the curve does its work.
          w = int'(dz_reg) + 40;
          x = $urandom_range(0, 2 * w);
          y = $urandom_range(0, 2 * w);
          send_item(make_item(jtm_pkg::REQ_SAMPLE, $urandom_range(0, 14) != 0,
                              clip_byte(int'(ctr_x) + x - w), clip_byte(int'(ctr_y) + y - w),
                              $urandom));
        end
      end
    end
  endtask

  // Receiver: ready follows a pattern that changes after a random run of cycles.
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_left = $urandom_range(20, 120);
    end
    rx_left--;
    rx_cycle++;
    case (rx_mode)
      RX_STEADY:        out_ready = 1'b1;
      RX_COIN:          out_ready = 1'($urandom_range(0, 1));
      RX_THREE_OF_FOUR: out_ready = (rx_cycle % 4) != 3;
      RX_SPARSE:        out_ready = $urandom_range(0, 15) == 0;
      default:          out_ready = 1'b1;
    endcase
  end

  always @(posedge clk) begin
    jtm_pkg::out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_reports.size() == 0) begin
        flag_error("report items with nothing predicted", 0, 1);
      end else begin
        want = expected_reports.pop_front();
        reports_checked++;
        if (out_data.report_valid !== want.report_valid)
          flag_error("report_valid", want.report_valid, out_data.report_valid);
        if (out_data.buttons !== want.buttons)
          flag_error("buttons", want.buttons, out_data.buttons);
        if (out_data.delta_x !== want.delta_x)
          flag_error("delta_x", int'($signed(want.delta_x)), int'($signed(out_data.delta_x)));
        if (out_data.delta_y !== want.delta_y)
          flag_error("delta_y", int'($signed(want.delta_y)), int'($signed(out_data.delta_y)));
        if (out_data.read_fault !== want.read_fault)
          flag_error("read_fault", want.read_fault, out_data.read_fault);
        if (out_data.ready_res !== want.ready_res)
          flag_error("ready_res", want.ready_res, out_data.ready_res);
        if (out_data.calibrating !== want.calibrating)
          flag_error("calibrating", want.calibrating, out_data.calibrating);
        if (out_data.center_x_out !== want.center_x_out)
          flag_error("center_x_out", want.center_x_out, out_data.center_x_out);
        if (out_data.center_y_out !== want.center_y_out)
          flag_error("center_y_out", want.center_y_out, out_data.center_y_out);
      end
    end
  end

  // Watchdog: counts cycles in which work is pending but no item moves.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (!in_valid && expected_reports.size() == 0)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Timeout: no item moved for %0d cycles.", STALL_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = jtm_pkg::CFG_DEADZONE;
    cfg_data = '0;
    dz_reg = jtm_pkg::DEADZONE_RST;
    gain_reg = jtm_pkg::GAIN_RST;
    step_reg = jtm_pkg::MAX_STEP_RST;
    inv_x_reg = jtm_pkg::INVERT_X_RST;
    inv_y_reg = jtm_pkg::INVERT_Y_RST;
    ctr_x = jtm_pkg::CENTER_RST;
    ctr_y = jtm_pkg::CENTER_RST;
    acc_x = 0;
    acc_y = 0;
    good_seen = 0;
    attempts = 0;
    pred_ready = 1'b0;
    pred_cal = 1'b0;
    pred_fault = 1'b0;
    burst_left = 0;
    items_sent = 0;
    reports_checked = 0;
    cal_requests = 0;
    settings_applied = 0;
    error_count = 0;
    idle_cycles = 0;
    rx_cycle = 0;
    rx_left = 0;
    rx_mode = RX_STEADY;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_idle_samples();
    test_calibration_extremes();
    test_register_extremes();
    test_recalibration();
    test_random_traffic();

    settle_block();
    repeat (10) @(posedge clk);
    $display("Sent %0d items (%0d calibrate requests) under %0d register settings.",
             items_sent, cal_requests, settings_applied);
    $display("Checked %0d reports, %0d mismatching fields.", reports_checked, error_count);
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/jtm_pkg.sv
hw/rtl/joystick_to_mouse_delta.sv
sim/joystick_to_mouse_delta_test.sv
